[hdl/assert_macros.svh]
// Assertion macros used by the frame receiver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hdl/dfr_pkg.sv]
// Package with types and constants of the delimited frame receiver.
`default_nettype none

package dfr_pkg;

  localparam int unsigned FRAME_BYTES = 64;
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [31:0] ERR_FLAG_MASK = 32'h0000_000F;
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    LINK_NONE     = 2'd0,
    LINK_LINE     = 2'd1,
    LINK_OVERFLOW = 2'd2
  } link_mode_e;

  typedef struct packed {
    logic       active_buffer;
    logic       ready_first;
    logic       ready_second;
    logic [6:0] count_first;
    logic [6:0] count_second;
    logic [1:0] link_status;
    logic       frame_done;
  } status_t;

  typedef struct packed {
    logic    valid;
    logic    read_hit;
    status_t status;
  } issue_t;

  typedef struct packed {
    logic [7:0] read_data;
    status_t    status;
  } result_t;

endpackage

`default_nettype wire

[hdl/dfr_if.sv]
// Handshake interfaces for the input and result channels.
`default_nettype none

interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;
  logic [3:0] rx_error_flags;
  logic       read_buffer;
  logic [5:0] read_index;

  modport source (output valid, kind, rx_byte, rx_error_flags, read_buffer, read_index,
                  input ready);
  modport sink (input valid, kind, rx_byte, rx_error_flags, read_buffer, read_index,
                output ready);
endinterface

interface dfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       active_buffer;
  logic       ready_first;
  logic       ready_second;
  logic [6:0] count_first;
  logic [6:0] count_second;
  logic [1:0] link_status;
  logic       frame_done;

  modport source (output valid, read_data, active_buffer, ready_first, ready_second,
                  count_first, count_second, link_status, frame_done,
                  input ready);
  modport sink (input valid, read_data, active_buffer, ready_first, ready_second,
                count_first, count_second, link_status, frame_done,
                output ready);
endinterface

`default_nettype wire

[hdl/dfr_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none

module dfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/dfr_front.sv]
// Front end: accepts words, updates the framing state and issues store accesses.
`default_nettype none

module dfr_front #(
  parameter int unsigned FrameBytes = dfr_pkg::FRAME_BYTES,
  localparam int unsigned AddrW = (2 * FrameBytes > 1) ? $clog2(2 * FrameBytes) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  dfr_in_if.sink                 in_i,
  input  wire logic              space_i,
  output dfr_pkg::issue_t        issue_o,
  output logic                   ram_we_o,
  output logic                   ram_re_o,
  output logic       [AddrW-1:0] ram_addr_o,
  output logic       [7:0]       ram_wdata_o
);

  localparam int unsigned CntW = $clog2(FrameBytes + 1);

  logic                 sel_q, sel_d;
  dfr_pkg::link_mode_e  mode_q, mode_d;
  logic [CntW-1:0]      cnt_q [2];
  logic [CntW-1:0]      cnt_d [2];
  logic [1:0]           rdy_q, rdy_d;
  logic                 accept;
  logic                 done;
  logic                 hit;

  assign in_i.ready = space_i;
  assign accept     = in_i.valid & space_i;

  always_comb begin
    sel_d       = sel_q;
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    rdy_d       = rdy_q;
    done        = 1'b0;
    hit         = 1'b0;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = '0;
    ram_wdata_o = in_i.rx_byte;
    if (accept) begin
      if (in_i.kind == dfr_pkg::KIND_READ) begin
        hit        = 9'(in_i.read_index) < 9'(FrameBytes);
        ram_re_o   = hit;
        ram_addr_o = in_i.read_buffer ? AddrW'(FrameBytes) + AddrW'(in_i.read_index)
                                      : AddrW'(in_i.read_index);
      end else if ((in_i.rx_error_flags & dfr_pkg::ERR_FLAG_MASK[3:0]) != 4'd0) begin
        mode_d = dfr_pkg::LINK_LINE;
      end else if (in_i.rx_byte == dfr_pkg::FLAG_BYTE) begin
        if (mode_q != dfr_pkg::LINK_NONE) begin
          mode_d        = dfr_pkg::LINK_NONE;
          rdy_d[sel_q]  = 1'b0;
          cnt_d[sel_q]  = '0;
        end else begin
          if (cnt_q[sel_q] != '0) begin
            rdy_d[sel_q] = 1'b1;
            done         = 1'b1;
          end
          sel_d         = ~sel_q;
          cnt_d[~sel_q] = '0;
          rdy_d[~sel_q] = 1'b0;
        end
      end else if (mode_q == dfr_pkg::LINK_NONE) begin
        if (cnt_q[sel_q] >= CntW'(FrameBytes)) begin
          mode_d = dfr_pkg::LINK_OVERFLOW;
        end else begin
          ram_we_o     = 1'b1;
          ram_addr_o   = sel_q ? AddrW'(FrameBytes) + AddrW'(cnt_q[sel_q])
                               : AddrW'(cnt_q[sel_q]);
          cnt_d[sel_q] = cnt_q[sel_q] + CntW'(1);
        end
      end
    end
  end

  always_comb begin
    issue_o.valid                = accept;
    issue_o.read_hit             = hit;
    issue_o.status.active_buffer = sel_d;
    issue_o.status.ready_first   = rdy_d[0];
    issue_o.status.ready_second  = rdy_d[1];
    issue_o.status.count_first   = 7'(cnt_d[0]);
    issue_o.status.count_second  = 7'(cnt_d[1]);
    issue_o.status.link_status   = mode_d;
    issue_o.status.frame_done    = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q    <= 1'b0;
      mode_q   <= dfr_pkg::LINK_NONE;
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
      rdy_q    <= '0;
    end else begin
      sel_q  <= sel_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      rdy_q  <= rdy_d;
    end
  end

endmodule

`default_nettype wire

[hdl/dfr_back.sv]
// Back end: joins read data with the status and queues result words.
`default_nettype none

module dfr_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dfr_pkg::issue_t issue_i,
  input  wire logic [7:0]      rdata_i,
  output logic                 space_o,
  dfr_out_if.source            out_o
);

  logic                             s1_valid_q;
  dfr_pkg::issue_t                  s1_q;
  dfr_pkg::result_t                 queue_q [dfr_pkg::QDEPTH];
  dfr_pkg::result_t                 push_word;
  logic [dfr_pkg::QPTR_W-1:0]       wptr_q, rptr_q;
  logic [dfr_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                             push, pop;

  assign push = s1_valid_q;
  assign pop  = out_o.valid & out_o.ready;

  assign push_word.read_data = s1_q.read_hit ? rdata_i : 8'd0;
  assign push_word.status    = s1_q.status;

  assign space_o = (count_q + dfr_pkg::QCNT_W'(s1_valid_q))
                   < dfr_pkg::QCNT_W'(dfr_pkg::QDEPTH);

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + dfr_pkg::QCNT_W'(1);
    end else if (!push && pop) begin
      count_d = count_q - dfr_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= issue_i;
    if (push) begin
      queue_q[wptr_q] <= push_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      count_q    <= '0;
    end else begin
      s1_valid_q <= issue_i.valid;
      count_q    <= count_d;
      if (push) begin
        wptr_q <= wptr_q + dfr_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + dfr_pkg::QPTR_W'(1);
      end
    end
  end

  assign out_o.valid         = count_q != '0;
  assign out_o.read_data     = queue_q[rptr_q].read_data;
  assign out_o.active_buffer = queue_q[rptr_q].status.active_buffer;
  assign out_o.ready_first   = queue_q[rptr_q].status.ready_first;
  assign out_o.ready_second  = queue_q[rptr_q].status.ready_second;
  assign out_o.count_first   = queue_q[rptr_q].status.count_first;
  assign out_o.count_second  = queue_q[rptr_q].status.count_second;
  assign out_o.link_status   = queue_q[rptr_q].status.link_status;
  assign out_o.frame_done    = queue_q[rptr_q].status.frame_done;

endmodule

`default_nettype wire

[hdl/delimited_frame_receiver_pingpong.sv]
// Top level of the delimited frame receiver with two ping-pong frame buffers.
//
//   Channel  Direction  Words
//   in_i     sink       received bytes and reads of stored frame bytes
//   out_o    source     one status word, with read data, for every input word
//
// One input word is taken every cycle while in_i.ready is high; its result word is offered
// after the registered read of the frame store and a four-word result queue.
// Reset clears the fill state, error mode, counts and ready marks; the store is not cleared.
// When the result side stalls, the queue fills and in_i.ready falls once the queue
// and the word in flight would take all four places.
`default_nettype none
`include "assert_macros.svh"

module delimited_frame_receiver_pingpong #(
  parameter int unsigned FrameBytes = dfr_pkg::FRAME_BYTES
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dfr_in_if.sink    in_i,
  dfr_out_if.source out_o
);

  localparam int unsigned AddrW = (2 * FrameBytes > 1) ? $clog2(2 * FrameBytes) : 1;

  dfr_pkg::issue_t  issue;
  logic             space;
  logic             ram_we;
  logic             ram_re;
  logic [AddrW-1:0] ram_addr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  dfr_front #(.FrameBytes(FrameBytes)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .space_i    (space),
    .issue_o    (issue),
    .ram_we_o   (ram_we),
    .ram_re_o   (ram_re),
    .ram_addr_o (ram_addr),
    .ram_wdata_o(ram_wdata)
  );

  dfr_ram #(.Width(8), .Depth(2 * FrameBytes)) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  dfr_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .issue_i(issue),
    .rdata_i(ram_rdata),
    .space_o(space),
    .out_o  (out_o)
  );

  `ASSERT_IMPLIES(a_done_marks_ready, clk_i, rst_ni, out_o.valid && out_o.frame_done, (out_o.active_buffer ? out_o.ready_first : out_o.ready_second))
  `ASSERT_IMPLIES(a_overflow_full, clk_i, rst_ni, out_o.valid && (out_o.link_status == dfr_pkg::LINK_OVERFLOW), ((out_o.active_buffer ? out_o.count_second : out_o.count_first) == 7'(FrameBytes)))
  `ASSERT_IMPLIES(a_write_not_read, clk_i, rst_ni, ram_we, !ram_re && issue.valid)
  `ASSERT_NEXT(a_full_holds_off, clk_i, rst_ni, out_o.valid && !out_o.ready && !in_i.ready, !in_i.ready)

endmodule

`default_nettype wire
